@@ rtl/core/nfcta_pkg.sv @@
`default_nettype none
package nfcta_pkg;

    localparam logic [1:0] KIND_START = 2'd0;
    localparam logic [1:0] KIND_BYTE  = 2'd1;
    localparam logic [1:0] KIND_FAIL  = 2'd2;
    localparam logic [1:0] KIND_RSVD  = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NO_DEVICE = 2'd1;
    localparam logic [1:0] ST_ATQA_BAD  = 2'd2;
    localparam logic [1:0] ST_IO_ERROR  = 2'd3;

    localparam logic [15:0] CRC_PRESET  = 16'h6363;
    localparam logic [7:0]  CMD_WUPA    = 8'h52;
    localparam logic [7:0]  CMD_SEL1    = 8'h93;
    localparam logic [7:0]  NVB_ANTICOL = 8'h20;
    localparam logic [7:0]  NVB_SELECT  = 8'h70;
    localparam logic [7:0]  CMD_RATS    = 8'hE0;
    localparam logic [7:0]  SAK_CASCADE = 8'h04;
    localparam logic [7:0]  SAK_TCL_MSK = 8'h24;
    localparam logic [7:0]  SAK_TCL_VAL = 8'h20;
    localparam logic [4:0]  RX_IDX_MAX  = 5'd31;
    localparam logic [3:0]  UID_MAX     = 4'd10;
    localparam logic [3:0]  FSD_RESET   = 4'd8;
    localparam logic [3:0]  FWI_DEFAULT = 4'd8;

    localparam int TDATA_W = 128;

    typedef enum logic [4:0] {
        PH_IDLE = 5'b00001,
        PH_ATQA = 5'b00010,
        PH_UID  = 5'b00100,
        PH_SAK  = 5'b01000,
        PH_ATS  = 5'b10000
    } phase_t;

    typedef enum logic [7:0] {
        S_WAIT   = 8'b00000001,
        S_FRAME  = 8'b00000010,
        S_SAKCRC = 8'b00000100,
        S_SAKCHK = 8'b00001000,
        S_ADDUID = 8'b00010000,
        S_NEXT   = 8'b00100000,
        S_SEND   = 8'b01000000,
        S_DONE   = 8'b10000000
    } seq_t;

    typedef struct packed {
        logic       preset;
        logic       step;
        logic [7:0] data;
    } crc_cmd_t;

    typedef struct packed {
        logic       clear;
        logic       add;
        logic [7:0] data;
    } uid_cmd_t;

    // CRC-A, one byte (ITU-V.41 reflected form)
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [7:0] ch;
        ch = b ^ crc[7:0];
        ch = ch ^ {ch[3:0], 4'b0};
        return {8'h00, crc[15:8]} ^ {ch, 8'h00} ^ {5'b0, ch, 3'b0} ^ {12'h000, ch[7:4]};
    endfunction

endpackage
`default_nettype wire

@@ rtl/core/nfcta_crc.sv @@
`default_nettype none
module nfcta_crc
    import nfcta_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire crc_cmd_t    cmd,
    output logic [15:0]      crc
);
    logic [15:0] crc_reg, crc_next;

    always_comb begin
        crc_next = crc_reg;
        if (cmd.preset) begin
            crc_next = CRC_PRESET;
        end else if (cmd.step) begin
            crc_next = crc_byte(crc_reg, cmd.data);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg <= CRC_PRESET;
        end else begin
            crc_reg <= crc_next;
        end
    end

    assign crc = crc_reg;
endmodule
`default_nettype wire

@@ rtl/core/nfcta_uid.sv @@
`default_nettype none
module nfcta_uid
    import nfcta_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire uid_cmd_t    cmd,
    output logic [3:0]       uid_count,
    output logic [63:0]      uid_low,
    output logic [15:0]      uid_high
);
    logic [7:0] store_reg [10];
    logic [3:0] count_reg, count_next;

    always_comb begin
        count_next = count_reg;
        if (cmd.clear) begin
            count_next = 4'd0;
        end else if (cmd.add && count_reg < UID_MAX) begin
            count_next = count_reg + 4'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 4'd0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!cmd.clear && cmd.add && count_reg < UID_MAX) begin
            store_reg[count_reg] <= cmd.data;
        end
    end

    // bytes past the count read as zero
    always_comb begin
        for (int i = 0; i < 8; i++) begin
            uid_low[8*i +: 8] = (4'(i) < count_reg) ? store_reg[i] : 8'h00;
        end
        for (int i = 0; i < 2; i++) begin
            uid_high[8*i +: 8] = (4'(i + 8) < count_reg) ? store_reg[i + 8] : 8'h00;
        end
    end

    assign uid_count = count_reg;
endmodule
`default_nettype wire

@@ rtl/core/nfc_type_a_card_activation_core.sv @@
// Type A card activation sequencer, reader side.
// s_ channel takes requests: s_tuser = kind (start, received byte, receive failure),
// s_tdata = received byte, s_tlast = last byte of the received frame.
// m_ channel gives transmit bytes (m_tlast ends a transmit frame, m_tuser[0] marks a
// 7-bit short frame) and one done result per run (m_tuser[1]) carrying status and
// the gathered card data in m_tdata.
// A frame end is evaluated in S_FRAME; after a SAK it goes on to the CRC check (only
// with the cascade bit clear), UID collection and next-frame choice.
// The transmit frame then leaves one byte per cycle through the output register while
// m_tready does not stall it, up to 9 bytes, with the CRC-A computed by one shared
// byte-wide CRC unit as the bytes go out.
// s_tready is high only while the sequencer waits for the next request; a stalled
// m_tready holds the current result and the sequencer with it.
// fsd_index is written through cfg_wr_en/cfg_wr_data; the user must write it only
// while no run is in progress, as the block itself does not enforce it.
// Reset (aresetn low, synchronous) returns to idle, fsd_index 8, no result pending.
`default_nettype none
module nfc_type_a_card_activation_core
    import nfcta_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_wr_en,
    input  wire logic [3:0]         cfg_wr_data,   // fsd_index
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [7:0]         s_tdata,       // rx_byte
    input  wire logic [1:0]         s_tuser,       // kind
    input  wire logic               s_tlast,       // rx_last
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    // tx_byte[7:0] status[9:8] atqa_word[25:10] select_ack[33:26] uid_length[37:34]
    // uid_low[101:38] uid_high[117:102] card_frame_index[121:118] wait_index[125:122]
    output logic [TDATA_W-1:0]      m_tdata,
    output logic [1:0]              m_tuser,       // tx_short, done_res
    output logic                    m_tlast        // tx_last
);
    seq_t        seq_reg, seq_next;
    phase_t      phase_reg, phase_next;
    logic [1:0]  casc_reg, casc_next;
    logic [1:0]  lvcnt_reg, lvcnt_next;
    logic [4:0]  rx_idx_reg, rx_idx_next;
    logic [4:0]  n_reg, n_next;
    logic [7:0]  lvl_reg [5];
    logic [7:0]  lvl_next [5];
    logic [15:0] atqa_reg, atqa_next;
    logic [7:0]  sak_reg [3];
    logic [7:0]  sak_next [3];
    logic [7:0]  ats_reg [4];
    logic [7:0]  ats_next [4];
    logic [7:0]  fsak_reg, fsak_next;
    logic [3:0]  fsci_reg, fsci_next;
    logic [3:0]  fwi_reg, fwi_next;
    logic [3:0]  fsd_reg, fsd_next;
    logic [1:0]  status_reg, status_next;
    logic [7:0]  txb_reg [7];
    logic [7:0]  txb_next [7];
    logic [2:0]  txlen_reg, txlen_next;
    logic        txcrc_reg, txcrc_next;
    logic        txshort_reg, txshort_next;
    logic [3:0]  txidx_reg, txidx_next;
    logic [1:0]  src_reg, src_next;

    logic                 mvalid_reg, mvalid_next;
    logic [TDATA_W-1:0]   mdata_reg, mdata_next;
    logic [1:0]           muser_reg, muser_next;
    logic                 mlast_reg, mlast_next;

    crc_cmd_t    crc_cmd;
    uid_cmd_t    uid_cmd;
    logic [15:0] crc;
    logic [3:0]  uid_count;
    logic [63:0] uid_low;
    logic [15:0] uid_high;

    logic        accept, out_free;
    logic [7:0]  sel_code;
    logic [7:0]  ats_t0;
    logic [1:0]  lv;

    nfcta_crc u_crc (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (crc_cmd),
        .crc     (crc)
    );

    nfcta_uid u_uid (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (uid_cmd),
        .uid_count (uid_count),
        .uid_low   (uid_low),
        .uid_high  (uid_high)
    );

    assign s_tready = (seq_reg == S_WAIT);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !mvalid_reg || m_tready;
    assign sel_code = CMD_SEL1 + {5'b0, casc_reg, 1'b0};
    assign ats_t0   = ats_reg[1];
    assign lv       = atqa_reg[7:6];

    always_comb begin
        seq_next     = seq_reg;
        phase_next   = phase_reg;
        casc_next    = casc_reg;
        lvcnt_next   = lvcnt_reg;
        rx_idx_next  = rx_idx_reg;
        n_next       = n_reg;
        lvl_next     = lvl_reg;
        atqa_next    = atqa_reg;
        sak_next     = sak_reg;
        ats_next     = ats_reg;
        fsak_next    = fsak_reg;
        fsci_next    = fsci_reg;
        fwi_next     = fwi_reg;
        fsd_next     = cfg_wr_en ? cfg_wr_data : fsd_reg;
        status_next  = status_reg;
        txb_next     = txb_reg;
        txlen_next   = txlen_reg;
        txcrc_next   = txcrc_reg;
        txshort_next = txshort_reg;
        txidx_next   = txidx_reg;
        src_next     = src_reg;
        mvalid_next  = mvalid_reg && !m_tready;
        mdata_next   = mdata_reg;
        muser_next   = muser_reg;
        mlast_next   = mlast_reg;
        crc_cmd      = '0;
        uid_cmd      = '0;

        case (seq_reg)
            S_WAIT: begin
                if (accept) begin
                    if (s_tuser == KIND_START) begin
                        casc_next    = 2'd0;
                        lvcnt_next   = 2'd0;
                        rx_idx_next  = 5'd0;
                        uid_cmd.clear = 1'b1;
                        atqa_next    = 16'h0000;
                        fsak_next    = 8'h00;
                        fsci_next    = 4'd0;
                        fwi_next     = FWI_DEFAULT;
                        for (int i = 0; i < 4; i++) ats_next[i] = 8'h00;
                        phase_next   = PH_ATQA;
                        txb_next[0]  = CMD_WUPA;
                        txlen_next   = 3'd1;
                        txcrc_next   = 1'b0;
                        txshort_next = 1'b1;
                        txidx_next   = 4'd0;
                        crc_cmd.preset = 1'b1;
                        seq_next     = S_SEND;
                    end else if (phase_reg != PH_IDLE && s_tuser == KIND_FAIL) begin
                        rx_idx_next = 5'd0;
                        status_next = (phase_reg == PH_ATQA) ? ST_NO_DEVICE : ST_IO_ERROR;
                        seq_next    = S_DONE;
                    end else if (phase_reg != PH_IDLE && s_tuser == KIND_BYTE) begin
                        case (phase_reg)
                            PH_ATQA: begin
                                if (rx_idx_reg == 5'd0) atqa_next[7:0] = s_tdata;
                                else if (rx_idx_reg == 5'd1) atqa_next[15:8] = s_tdata;
                            end
                            PH_UID: begin
                                if (rx_idx_reg < 5'd5) lvl_next[rx_idx_reg[2:0]] = s_tdata;
                            end
                            PH_SAK: begin
                                if (rx_idx_reg < 5'd3) sak_next[rx_idx_reg[1:0]] = s_tdata;
                            end
                            PH_ATS: begin
                                if (rx_idx_reg < 5'd4) ats_next[rx_idx_reg[1:0]] = s_tdata;
                            end
                            default: ;
                        endcase
                        if (rx_idx_reg < RX_IDX_MAX) rx_idx_next = rx_idx_reg + 5'd1;
                        if (s_tlast) begin
                            n_next      = (rx_idx_reg < RX_IDX_MAX) ? rx_idx_reg + 5'd1
                                                                   : rx_idx_reg;
                            rx_idx_next = 5'd0;
                            seq_next    = S_FRAME;
                        end
                    end
                end
            end
            S_FRAME: begin
                case (phase_reg)
                    PH_ATQA: begin
                        if (n_reg < 5'd2) begin
                            status_next = ST_IO_ERROR;
                            seq_next    = S_DONE;
                        end else if (atqa_reg[4:0] == 5'd0) begin
                            status_next = ST_ATQA_BAD;
                            seq_next    = S_DONE;
                        end else if (lv == 2'd3) begin
                            status_next = ST_IO_ERROR;
                            seq_next    = S_DONE;
                        end else begin
                            lvcnt_next   = lv;
                            casc_next    = 2'd0;
                            phase_next   = PH_UID;
                            txb_next[0]  = CMD_SEL1;
                            txb_next[1]  = NVB_ANTICOL;
                            txlen_next   = 3'd2;
                            txcrc_next   = 1'b0;
                            txshort_next = 1'b0;
                            txidx_next   = 4'd0;
                            crc_cmd.preset = 1'b1;
                            seq_next     = S_SEND;
                        end
                    end
                    PH_UID: begin
                        if (n_reg < 5'd5 ||
                            (lvl_reg[0] ^ lvl_reg[1] ^ lvl_reg[2] ^ lvl_reg[3]) != lvl_reg[4]) begin
                            status_next = ST_IO_ERROR;
                            seq_next    = S_DONE;
                        end else begin
                            phase_next   = PH_SAK;
                            txb_next[0]  = sel_code;
                            txb_next[1]  = NVB_SELECT;
                            for (int i = 0; i < 5; i++) txb_next[i + 2] = lvl_reg[i];
                            txlen_next   = 3'd7;
                            txcrc_next   = 1'b1;
                            txshort_next = 1'b0;
                            txidx_next   = 4'd0;
                            crc_cmd.preset = 1'b1;
                            seq_next     = S_SEND;
                        end
                    end
                    PH_SAK: begin
                        if (n_reg < 5'd3) begin
                            status_next = ST_IO_ERROR;
                            seq_next    = S_DONE;
                        end else if ((sak_reg[0] & SAK_CASCADE) == 8'h00) begin
                            crc_cmd.preset = 1'b1;
                            seq_next       = S_SAKCRC;
                        end else begin
                            // cascade tag in byte 0 is skipped
                            src_next = 2'd1;
                            seq_next = S_ADDUID;
                        end
                    end
                    PH_ATS: begin
                        seq_next    = S_DONE;
                        status_next = ST_OK;
                        if (ats_reg[0] > 8'd1) begin
                            if (n_reg < 5'd2) begin
                                status_next = ST_IO_ERROR;
                            end else begin
                                fsci_next = ats_t0[3:0];
                                if (ats_t0[5]) begin
                                    if (ats_t0[4]) begin
                                        if (n_reg <= 5'd3) status_next = ST_IO_ERROR;
                                        else fwi_next = ats_reg[3][7:4];
                                    end else begin
                                        if (n_reg <= 5'd2) status_next = ST_IO_ERROR;
                                        else fwi_next = ats_reg[2][7:4];
                                    end
                                end
                            end
                        end
                    end
                    default: seq_next = S_WAIT;
                endcase
            end
            S_SAKCRC: begin
                crc_cmd.step = 1'b1;
                crc_cmd.data = sak_reg[0];
                seq_next     = S_SAKCHK;
            end
            S_SAKCHK: begin
                if (crc != {sak_reg[2], sak_reg[1]}) begin
                    status_next = ST_IO_ERROR;
                    seq_next    = S_DONE;
                end else begin
                    fsak_next = sak_reg[0];
                    src_next  = 2'd0;
                    seq_next  = S_ADDUID;
                end
            end
            S_ADDUID: begin
                uid_cmd.add  = 1'b1;
                uid_cmd.data = lvl_reg[{1'b0, src_reg}];
                src_next     = src_reg + 2'd1;
                if (src_reg == 2'd3) seq_next = S_NEXT;
            end
            S_NEXT: begin
                txidx_next   = 4'd0;
                txshort_next = 1'b0;
                if (casc_reg < lvcnt_reg) begin
                    casc_next    = casc_reg + 2'd1;
                    phase_next   = PH_UID;
                    txb_next[0]  = sel_code + 8'd2;
                    txb_next[1]  = NVB_ANTICOL;
                    txlen_next   = 3'd2;
                    txcrc_next   = 1'b0;
                    crc_cmd.preset = 1'b1;
                    seq_next     = S_SEND;
                end else if ((fsak_reg & SAK_TCL_MSK) == SAK_TCL_VAL) begin
                    phase_next   = PH_ATS;
                    txb_next[0]  = CMD_RATS;
                    txb_next[1]  = {fsd_reg, 4'h0};
                    txlen_next   = 3'd2;
                    txcrc_next   = 1'b1;
                    crc_cmd.preset = 1'b1;
                    seq_next     = S_SEND;
                end else begin
                    status_next = ST_OK;
                    seq_next    = S_DONE;
                end
            end
            S_SEND: begin
                if (out_free) begin
                    mvalid_next = 1'b1;
                    muser_next  = {1'b0, txshort_reg};
                    mdata_next  = '0;
                    txidx_next  = txidx_reg + 4'd1;
                    if (txidx_reg < {1'b0, txlen_reg}) begin
                        mdata_next[7:0] = txb_reg[txidx_reg[2:0]];
                        crc_cmd.step    = 1'b1;
                        crc_cmd.data    = txb_reg[txidx_reg[2:0]];
                        mlast_next      = !txcrc_reg && (txidx_reg == {1'b0, txlen_reg} - 4'd1);
                    end else if (txidx_reg == {1'b0, txlen_reg}) begin
                        mdata_next[7:0] = crc[7:0];
                        mlast_next      = 1'b0;
                    end else begin
                        mdata_next[7:0] = crc[15:8];
                        mlast_next      = 1'b1;
                    end
                    if (mlast_next) seq_next = S_WAIT;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    mvalid_next          = 1'b1;
                    muser_next           = 2'b10;
                    mlast_next           = 1'b0;
                    mdata_next           = '0;
                    mdata_next[9:8]      = status_reg;
                    mdata_next[25:10]    = atqa_reg;
                    mdata_next[33:26]    = fsak_reg;
                    mdata_next[37:34]    = uid_count;
                    mdata_next[101:38]   = uid_low;
                    mdata_next[117:102]  = uid_high;
                    mdata_next[121:118]  = fsci_reg;
                    mdata_next[125:122]  = fwi_reg;
                    phase_next           = PH_IDLE;
                    seq_next             = S_WAIT;
                end
            end
            default: seq_next = S_WAIT;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seq_reg    <= S_WAIT;
            phase_reg  <= PH_IDLE;
            casc_reg   <= 2'd0;
            lvcnt_reg  <= 2'd0;
            rx_idx_reg <= 5'd0;
            atqa_reg   <= 16'h0000;
            fsak_reg   <= 8'h00;
            fsci_reg   <= 4'd0;
            fwi_reg    <= FWI_DEFAULT;
            fsd_reg    <= FSD_RESET;
            mvalid_reg <= 1'b0;
        end else begin
            seq_reg    <= seq_next;
            phase_reg  <= phase_next;
            casc_reg   <= casc_next;
            lvcnt_reg  <= lvcnt_next;
            rx_idx_reg <= rx_idx_next;
            atqa_reg   <= atqa_next;
            fsak_reg   <= fsak_next;
            fsci_reg   <= fsci_next;
            fwi_reg    <= fwi_next;
            fsd_reg    <= fsd_next;
            mvalid_reg <= mvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 4; i++) ats_reg[i] <= 8'h00;
            for (int i = 0; i < 3; i++) sak_reg[i] <= 8'h00;
        end else begin
            ats_reg <= ats_next;
            sak_reg <= sak_next;
        end
    end

    always_ff @(posedge aclk) begin
        n_reg       <= n_next;
        lvl_reg     <= lvl_next;
        status_reg  <= status_next;
        txb_reg     <= txb_next;
        txlen_reg   <= txlen_next;
        txcrc_reg   <= txcrc_next;
        txshort_reg <= txshort_next;
        txidx_reg   <= txidx_next;
        src_reg     <= src_next;
        mdata_reg   <= mdata_next;
        muser_reg   <= muser_next;
        mlast_reg   <= mlast_next;
    end

    assign m_tvalid = mvalid_reg;
    assign m_tdata  = mdata_reg;
    assign m_tuser  = muser_reg;
    assign m_tlast  = mlast_reg;
endmodule
`default_nettype wire
